// File: rtl/a2ti_pkg.sv
// Shared types and constants for the table-interpolated atan2 pipeline.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package a2ti_pkg;

    // Width of the blend fraction and of one table entry (Q0.16).
    localparam int BLEND_BITS = 16;

    // Interpolated angles are held with 32 fraction bits and two integer bits.
    localparam int THETA_FRAC = 2 * BLEND_BITS;
    localparam int THETA_W    = THETA_FRAC + 2;

    // Width of the angle result port.
    localparam int ANGLE_W = 16;

    // Quadrant and special-case flags that follow an item down the pipeline.
    typedef struct packed {
        logic swap;    // |y| > |x|: mirror about pi/2
        logic xneg;    // x < 0: mirror about pi
        logic yneg;    // y < 0: negate
        logic origin;  // x = y = 0
    } t_quad;

endpackage

`default_nettype wire

// File: rtl/a2ti_front.sv
// Front end: magnitudes and signs of the inputs, then min/max ordering and
// scaling of the numerator by the table size. Two register stages. Uses a2ti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module a2ti_front #(
    parameter int INPUT_WIDTH = 16,
    parameter int TABLE_SIZE  = 128,
    localparam int NB         = $clog2(TABLE_SIZE + 1),
    localparam int DIV_W      = INPUT_WIDTH + NB
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [INPUT_WIDTH-1:0] i_y_coord,
    input  logic signed [INPUT_WIDTH-1:0] i_x_coord,
    output logic                          o_valid,
    output logic        [DIV_W-1:0]       o_dividend,
    output logic        [INPUT_WIDTH-1:0] o_den,
    output a2ti_pkg::t_quad               o_quad
);
    import a2ti_pkg::*;

    localparam int W = INPUT_WIDTH;

    logic         r_vld1, r_vld2;
    logic [W-1:0] r_ay, r_ax;
    t_quad        r_quad1, r_quad2;
    logic [DIV_W-1:0] r_dividend;
    logic [W-1:0] r_den;

    logic [W-1:0] n_ay, n_ax;
    t_quad        n_quad1, n_quad2;
    logic [DIV_W-1:0] n_dividend;
    logic [W-1:0] n_den;

    always_comb begin
        logic [W-1:0] y_bits;
        logic [W-1:0] x_bits;
        y_bits = $unsigned(i_y_coord);
        x_bits = $unsigned(i_x_coord);
        // The most negative code maps to 2^(W-1), which still fits in W bits.
        n_ay = y_bits[W-1] ? W'(0) - y_bits : y_bits;
        n_ax = x_bits[W-1] ? W'(0) - x_bits : x_bits;
        n_quad1.swap   = 1'b0;
        n_quad1.xneg   = x_bits[W-1];
        n_quad1.yneg   = y_bits[W-1];
        n_quad1.origin = (y_bits == '0) && (x_bits == '0);
    end

    always_comb begin
        logic [W-1:0] num;
        num          = (r_ay < r_ax) ? r_ay : r_ax;
        n_den        = (r_ay < r_ax) ? r_ax : r_ay;
        n_quad2      = r_quad1;
        n_quad2.swap = r_ay > r_ax;
        n_dividend   = DIV_W'(num) * DIV_W'(TABLE_SIZE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ay       <= n_ay;
        r_ax       <= n_ax;
        r_quad1    <= n_quad1;
        r_dividend <= n_dividend;
        r_den      <= n_den;
        r_quad2    <= n_quad2;
    end

    assign o_valid    = r_vld2;
    assign o_dividend = r_dividend;
    assign o_den      = r_den;
    assign o_quad     = r_quad2;

endmodule

`default_nettype wire

// File: rtl/a2ti_divider.sv
// Pipelined restoring divider: one quotient bit per register stage gives the
// ratio min*TABLE_SIZE*2^16/max. Uses a2ti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module a2ti_divider #(
    parameter int INPUT_WIDTH = 16,
    parameter int TABLE_SIZE  = 128,
    localparam int NB         = $clog2(TABLE_SIZE + 1),
    localparam int DIV_W      = INPUT_WIDTH + NB,
    localparam int QB         = NB + a2ti_pkg::BLEND_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [DIV_W-1:0]       i_dividend,
    input  logic [INPUT_WIDTH-1:0] i_den,
    input  a2ti_pkg::t_quad        i_quad,
    output logic                   o_valid,
    output logic [QB-1:0]          o_ratio,
    output a2ti_pkg::t_quad        o_quad
);
    import a2ti_pkg::*;

    localparam int W = INPUT_WIDTH;

    logic [W-1:0]  r_rem  [QB];
    logic [W-1:0]  r_den  [QB];
    logic [QB-1:0] r_quo  [QB];
    logic [QB-1:0] r_feed [QB];
    t_quad         r_quad [QB];
    logic [QB-1:0] r_vld;

    logic [W-1:0]  n_rem  [QB];
    logic [W-1:0]  n_den  [QB];
    logic [QB-1:0] n_quo  [QB];
    logic [QB-1:0] n_feed [QB];
    t_quad         n_quad [QB];
    logic [QB-1:0] n_vld;

    // The quotient is below 2^QB, so the dividend bits above the low NB bits
    // already form a partial remainder smaller than the divisor. The stages
    // then shift in the low NB bits followed by the 16 fraction zeros.
    always_comb begin
        logic [W-1:0]  p_rem;
        logic [W-1:0]  p_den;
        logic [QB-1:0] p_quo;
        logic [QB-1:0] p_feed;
        t_quad         p_quad;
        logic [W:0]    trial;
        logic          take;
        for (int s = 0; s < QB; s++) begin
            if (s == 0) begin
                p_rem  = i_dividend[DIV_W-1:NB];
                p_den  = i_den;
                p_quo  = '0;
                p_feed = {i_dividend[NB-1:0], BLEND_BITS'(0)};
                p_quad = i_quad;
            end else begin
                p_rem  = r_rem[s-1];
                p_den  = r_den[s-1];
                p_quo  = r_quo[s-1];
                p_feed = r_feed[s-1];
                p_quad = r_quad[s-1];
            end
            trial     = {p_rem, p_feed[QB-1]};
            take      = trial >= {1'b0, p_den};
            n_rem[s]  = take ? W'(trial - {1'b0, p_den}) : W'(trial);
            n_quo[s]  = {p_quo[QB-2:0], take};
            n_feed[s] = {p_feed[QB-2:0], 1'b0};
            n_den[s]  = p_den;
            n_quad[s] = p_quad;
        end
        n_vld = {r_vld[QB-2:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quo  <= n_quo;
        r_feed <= n_feed;
        r_quad <= n_quad;
    end

    assign o_valid = r_vld[QB-1];
    assign o_ratio = r_quo[QB-1];
    assign o_quad  = r_quad[QB-1];

endmodule

`default_nettype wire

// File: rtl/a2ti_interp.sv
// Arctangent ROM and linear interpolation: address clamp, registered ROM read,
// two weight multiplies, and the blend sum. Four register stages. Uses a2ti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module a2ti_interp #(
    parameter int TABLE_SIZE = 128,
    localparam int NB        = $clog2(TABLE_SIZE + 1),
    localparam int QB        = NB + a2ti_pkg::BLEND_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [QB-1:0]                  i_ratio,
    input  a2ti_pkg::t_quad                i_quad,
    output logic                           o_valid,
    output logic [a2ti_pkg::THETA_W-1:0]   o_theta,
    output a2ti_pkg::t_quad                o_quad
);
    import a2ti_pkg::*;

    localparam int STAGES       = 4;
    localparam int PROD_W       = 2 * BLEND_BITS + 1;
    localparam int SERIES_FRAC  = 40;
    localparam int SERIES_TERMS = 60;
    localparam int ROM_W        = (TABLE_SIZE + 1) * BLEND_BITS;

    // Entry i sits in bits [i*BLEND_BITS +: BLEND_BITS].
    typedef logic [ROM_W-1:0] t_rom;

    // Shift-and-subtract long division, used only while the table is built.
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int j = 63; j >= 0; j--) begin
            rem = {rem[63:0], a[j]};
            if (rem >= {1'b0, b}) begin
                rem    = rem - {1'b0, b};
                quo[j] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Entry i is atan(i/TABLE_SIZE) from an Euler series in 40-bit fixed
    // point, rounded half up to Q0.16. Evaluated once at elaboration.
    function automatic t_rom build_rom();
        t_rom        tab;
        logic [63:0] n;
        logic [63:0] ii;
        logic [63:0] d;
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] kk;
        tab = '0;
        n   = 64'(TABLE_SIZE);
        for (int i = 0; i <= TABLE_SIZE; i++) begin
            ii  = 64'(i);
            d   = n * n + ii * ii;
            t   = udiv64((ii * n) << SERIES_FRAC, d);
            sum = '0;
            for (int k = 1; k <= SERIES_TERMS; k++) begin
                kk  = 64'(k);
                sum = sum + t;
                t   = udiv64(t * (ii * ii), d);
                t   = udiv64(t * (64'd2 * kk), 64'd2 * kk + 64'd1);
            end
            tab[i*BLEND_BITS +: BLEND_BITS] =
                BLEND_BITS'((sum + (64'd1 << (SERIES_FRAC - BLEND_BITS - 1)))
                            >> (SERIES_FRAC - BLEND_BITS));
        end
        return tab;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [STAGES-1:0]     r_vld;
    t_quad                 r_quad [STAGES];
    logic [NB-1:0]         r_a0, r_a1;
    logic [BLEND_BITS-1:0] r_frac1, r_frac2;
    logic [BLEND_BITS-1:0] r_lo, r_hi;
    logic [PROD_W-1:0]     r_p0, r_p1;
    logic [THETA_W-1:0]    r_theta;

    logic [NB-1:0]         n_a0, n_a1;
    logic [BLEND_BITS-1:0] n_frac1;
    logic [PROD_W-1:0]     n_p0, n_p1;
    logic [THETA_W-1:0]    n_theta;

    // A ratio of one lands on the last entry with zero fraction; both reads
    // then point at that entry so nothing past the table is addressed.
    always_comb begin
        logic [NB-1:0]         idx;
        logic [BLEND_BITS-1:0] frac;
        logic                  clamp;
        idx     = i_ratio[QB-1:BLEND_BITS];
        frac    = i_ratio[BLEND_BITS-1:0];
        clamp   = idx >= NB'(TABLE_SIZE);
        n_a0    = clamp ? NB'(TABLE_SIZE) : idx;
        n_a1    = clamp ? NB'(TABLE_SIZE) : idx + NB'(1);
        n_frac1 = clamp ? '0 : frac;
    end

    always_comb begin
        logic [BLEND_BITS:0] w_lo;
        w_lo    = {1'b1, {BLEND_BITS{1'b0}}} - {1'b0, r_frac2};
        n_p0    = PROD_W'(r_lo) * PROD_W'(w_lo);
        n_p1    = PROD_W'(r_hi) * PROD_W'(r_frac2);
        n_theta = THETA_W'(r_p0) + THETA_W'(r_p1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_quad[0] <= i_quad;
        for (int s = 1; s < STAGES; s++) begin
            r_quad[s] <= r_quad[s-1];
        end
        r_a0    <= n_a0;
        r_a1    <= n_a1;
        r_frac1 <= n_frac1;
        r_lo    <= ROM[r_a0 * BLEND_BITS +: BLEND_BITS];
        r_hi    <= ROM[r_a1 * BLEND_BITS +: BLEND_BITS];
        r_frac2 <= r_frac1;
        r_p0    <= n_p0;
        r_p1    <= n_p1;
        r_theta <= n_theta;
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_theta = r_theta;
    assign o_quad  = r_quad[STAGES-1];

endmodule

`default_nettype wire

// File: rtl/a2ti_fixup.sv
// Quadrant corrections, rounding to the output format, sign and origin
// handling. Four register stages, the last one drives the result. Uses a2ti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module a2ti_fixup #(
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [a2ti_pkg::THETA_W-1:0]        i_theta,
    input  a2ti_pkg::t_quad                     i_quad,
    output logic                                o_valid,
    output logic signed [a2ti_pkg::ANGLE_W-1:0] o_angle,
    output logic                                o_undefined_origin
);
    import a2ti_pkg::*;

    localparam int STAGES = 4;

    // pi and pi/2 with 32 fraction bits, rounded to nearest.
    localparam logic [THETA_W-1:0] PI_Q32      = THETA_W'(34'h3_243F_6A89);
    localparam logic [THETA_W-1:0] HALF_PI_Q32 = THETA_W'(34'h1_921F_B544);

    localparam int                 ROUND_SHIFT = THETA_FRAC - ANGLE_FRAC_BITS;
    localparam logic [THETA_W-1:0] ROUND_BIAS  = THETA_W'(1) << (ROUND_SHIFT - 1);

    logic [STAGES-1:0]  r_vld;
    t_quad              r_quad [STAGES];
    logic [THETA_W-1:0] r_t1, r_t2;
    logic [ANGLE_W-1:0] r_mag, r_angle;

    logic [THETA_W-1:0] n_t1, n_t2;
    logic [ANGLE_W-1:0] n_mag, n_angle;

    always_comb begin
        logic [THETA_W-1:0] rounded;
        n_t1    = i_quad.swap ? HALF_PI_Q32 - i_theta : i_theta;
        n_t2    = r_quad[0].xneg ? PI_Q32 - r_t1 : r_t1;
        rounded = r_t2 + ROUND_BIAS;
        // Wider angle formats wrap modulo the port width.
        n_mag   = ANGLE_W'(rounded >> ROUND_SHIFT);
        if (r_quad[2].origin) begin
            n_angle = '0;
        end else if (r_quad[2].yneg) begin
            n_angle = ANGLE_W'(0) - r_mag;
        end else begin
            n_angle = r_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_quad[0] <= i_quad;
        for (int s = 1; s < STAGES; s++) begin
            r_quad[s] <= r_quad[s-1];
        end
        r_t1    <= n_t1;
        r_t2    <= n_t2;
        r_mag   <= n_mag;
        r_angle <= n_angle;
    end

    assign o_valid            = r_vld[STAGES-1];
    assign o_angle            = $signed(r_angle);
    assign o_undefined_origin = r_quad[STAGES-1].origin;

endmodule

`default_nettype wire

// File: rtl/atan2_table_interpolated.sv
// Top level of the table-interpolated four-quadrant arctangent.
// Instantiates a2ti_front, a2ti_divider, a2ti_interp and a2ti_fixup; uses a2ti_pkg.
//
//   Channel   Handshake            Payload
//   command   start / busy         i_y_coord, i_x_coord
//   result    o_strobe (1 cycle)   o_angle, o_undefined_origin
//
// One coordinate pair may be transferred in every cycle in which busy is low. Each
// result passes through the front end, the divider, the interpolator and the
// fix-up stage; the divider, one quotient bit per stage, holds most of the stages.
// Reset clears every valid bit at once; busy is high only while reset is held.
// The receiver cannot stall, so results leave in command order without
// backpressure and the pipeline never holds.
`timescale 1ns / 1ps
`default_nettype none

module atan2_table_interpolated #(
    parameter int TABLE_SIZE      = 128,
    parameter int INPUT_WIDTH     = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [INPUT_WIDTH-1:0]       i_y_coord,
    input  logic signed [INPUT_WIDTH-1:0]       i_x_coord,
    output logic                                o_strobe,
    output logic signed [a2ti_pkg::ANGLE_W-1:0] o_angle,
    output logic                                o_undefined_origin
);
    import a2ti_pkg::*;

    localparam int NB    = $clog2(TABLE_SIZE + 1);
    localparam int DIV_W = INPUT_WIDTH + NB;
    localparam int QB    = NB + BLEND_BITS;

    logic                   accept;
    logic                   front_vld, div_vld, interp_vld;
    logic [DIV_W-1:0]       front_dividend;
    logic [INPUT_WIDTH-1:0] front_den;
    logic [QB-1:0]          div_ratio;
    logic [THETA_W-1:0]     interp_theta;
    t_quad                  front_quad, div_quad, interp_quad;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    a2ti_front #(
        .INPUT_WIDTH (INPUT_WIDTH),
        .TABLE_SIZE  (TABLE_SIZE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_y_coord  (i_y_coord),
        .i_x_coord  (i_x_coord),
        .o_valid    (front_vld),
        .o_dividend (front_dividend),
        .o_den      (front_den),
        .o_quad     (front_quad)
    );

    a2ti_divider #(
        .INPUT_WIDTH (INPUT_WIDTH),
        .TABLE_SIZE  (TABLE_SIZE)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (front_vld),
        .i_dividend (front_dividend),
        .i_den      (front_den),
        .i_quad     (front_quad),
        .o_valid    (div_vld),
        .o_ratio    (div_ratio),
        .o_quad     (div_quad)
    );

    a2ti_interp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_vld),
        .i_ratio (div_ratio),
        .i_quad  (div_quad),
        .o_valid (interp_vld),
        .o_theta (interp_theta),
        .o_quad  (interp_quad)
    );

    a2ti_fixup #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_fixup (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (interp_vld),
        .i_theta            (interp_theta),
        .i_quad             (interp_quad),
        .o_valid            (o_strobe),
        .o_angle            (o_angle),
        .o_undefined_origin (o_undefined_origin)
    );

endmodule

`default_nettype wire

// File: tb/sv/atan2_checker.sv
// Result checker for atan2_table_interpolated: watches both channels, predicts each angle
// and compares it with what the block returns. Depends on a2ti_pkg for the angle width.
`timescale 1ns / 1ps

module atan2_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic [15:0]                         i_y_coord,
    input  logic [15:0]                         i_x_coord,
    input  logic                                i_strobe,
    input  logic signed [a2ti_pkg::ANGLE_W-1:0] i_angle,
    input  logic                                i_undefined_origin,
    output int                                  o_errors,
    output int                                  o_pending
);

    localparam int TABLE_SIZE  = 128;
    localparam int FRAC_BITS   = 13;
    localparam int BLEND       = 16;
    localparam int SERIES_FRAC = 40;
    localparam int SERIES_LEN  = 60;

    localparam longint unsigned PI_Q60      = 64'h3243F6A8885A308D;
    localparam longint unsigned PI_Q32      = (PI_Q60 + (64'd1 << 27)) >> 28;
    localparam longint unsigned HALF_PI_Q32 = (PI_Q60 + (64'd1 << 28)) >> 29;

    typedef struct packed {
        logic signed [a2ti_pkg::ANGLE_W-1:0] angle;
        logic                                origin;
    } t_angle_expect;

    longint unsigned atan_rom [0:TABLE_SIZE];
    t_angle_expect   angle_queue [$];
    int              err_count     = 0;
    int              pending_count = 0;

    assign o_errors  = err_count;
    assign o_pending = pending_count;

    // The table holds atan(i/N) in Q0.16, from the Euler series
    // atan(a/b) = sum of t_k, t_1 = ab/(a^2+b^2), t_(k+1) = t_k * a^2/(a^2+b^2) * 2k/(2k+1).
    initial begin
        longint unsigned n, d, t, sum;
        n = TABLE_SIZE;
        for (longint unsigned i = 0; i <= n; i++) begin
            d   = n * n + i * i;
            t   = ((i * n) << SERIES_FRAC) / d;
            sum = 0;
            for (longint unsigned k = 1; k <= SERIES_LEN; k++) begin
                sum += t;
                t = (t * (i * i)) / d;
                t = (t * (2 * k)) / (2 * k + 1);
            end
            atan_rom[i] = (sum + (64'd1 << (SERIES_FRAC - 17))) >> (SERIES_FRAC - 16);
        end
    end

    function automatic t_angle_expect predict_atan2(input logic [15:0] y, input logic [15:0] x);
        longint unsigned ay, ax, num, den, ratio, idx, frac, theta, mag;
        t_angle_expect   e;
        ay = y[15] ? (64'd65536 - y) : {48'd0, y};
        ax = x[15] ? (64'd65536 - x) : {48'd0, x};
        if (ay == 0 && ax == 0) begin
            e.angle  = '0;
            e.origin = 1'b1;
            return e;
        end
        num   = (ay < ax) ? ay : ax;
        den   = (ay < ax) ? ax : ay;
        ratio = ((num * TABLE_SIZE) << BLEND) / den;
        idx   = ratio >> BLEND;
        frac  = ratio & ((64'd1 << BLEND) - 1);
        // A ratio of exactly one takes the last entry as it is.
        if (idx >= TABLE_SIZE) begin
            theta = atan_rom[TABLE_SIZE] << BLEND;
        end else begin
            theta = atan_rom[idx] * ((64'd1 << BLEND) - frac) + atan_rom[idx + 1] * frac;
        end
        if (ay > ax)
            theta = HALF_PI_Q32 - theta;
        if (x[15])
            theta = PI_Q32 - theta;
        mag = (theta + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
        if (y[15])
            mag = 64'd0 - mag;
        e.angle  = mag[a2ti_pkg::ANGLE_W-1:0];
        e.origin = 1'b0;
        return e;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_angle_expect want;
        if (i_rst_n) begin
            if (i_strobe) begin
                if (angle_queue.size() == 0) begin
                    report_mismatch("unexpected result (angle)", i_angle, 0);
                end else begin
                    want = angle_queue.pop_front();
                    pending_count--;
                    if (i_angle !== want.angle)
                        report_mismatch("angle", i_angle, want.angle);
                    if (i_undefined_origin !== want.origin)
                        report_mismatch("undefined_origin", i_undefined_origin, want.origin);
                end
            end
            if (i_start && !i_busy) begin
                angle_queue.push_back(predict_atan2(i_y_coord, i_x_coord));
                pending_count++;
            end
        end
    end

endmodule

// File: tb/sv/tb.sv
// Top of the atan2_table_interpolated testbench: clock, reset and coordinate stimulus.
// Depends on the block, a2ti_pkg and atan2_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb;

    localparam int  CYCLE_LIMIT = 300000;
    localparam int  DRAIN_WAIT  = 70;

    logic                                i_clk   = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                start   = 1'b0;
    logic                                busy;
    logic [15:0]                         y_coord = '0;
    logic [15:0]                         x_coord = '0;
    logic                                strobe;
    logic signed [a2ti_pkg::ANGLE_W-1:0] angle;
    logic                                undefined_origin;
    int                                  errors;
    int                                  pending;
    int                                  cycle_count = 0;

    atan2_table_interpolated dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_y_coord          (y_coord),
        .i_x_coord          (x_coord),
        .o_strobe           (strobe),
        .o_angle            (angle),
        .o_undefined_origin (undefined_origin)
    );

    atan2_checker u_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_y_coord          (y_coord),
        .i_x_coord          (x_coord),
        .i_strobe           (strobe),
        .i_angle            (angle),
        .i_undefined_origin (undefined_origin),
        .o_errors           (errors),
        .o_pending          (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb failed");
        $finish;
    end

    // Offers one pair after a random idle gap and returns at the edge that takes it.
    task automatic send_pair(input logic [15:0] y, input logic [15:0] x, input int idle_pct);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        y_coord <= y;
        x_coord <= x;
        // Busy changes only at rising edges, so its value at the falling edge holds
        // at the next rising edge.
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0001;
            3:       return 16'hFFFF;
            default: return 16'h0000;
        endcase
    endfunction

    task automatic make_pair(output logic [15:0] y, output logic [15:0] x);
        logic [15:0] m;
        case ($urandom_range(9))
            5: begin
                // Equal magnitudes give a ratio of exactly one, or the origin when m is zero.
                m = $urandom_range(32768);
                y = $urandom_range(1) ? -m : m;
                x = $urandom_range(1) ? -m : m;
            end
            6: begin
                y = $urandom_range(65535);
                x = $urandom_range(65535);
                if ($urandom_range(1))
                    y = '0;
                else
                    x = '0;
            end
            7: begin
                y = pick_extreme();
                x = pick_extreme();
            end
            8: begin
                y = 16'($signed($urandom_range(8)) - 4);
                x = 16'($signed($urandom_range(8)) - 4);
            end
            9: begin
                y = $urandom_range(65535);
                x = y + 16'($signed($urandom_range(6)) - 3);
                if ($urandom_range(1))
                    x = -x;
            end
            default: begin
                y = $urandom_range(65535);
                x = $urandom_range(65535);
            end
        endcase
    endtask

    task automatic run_random(input int count, input int idle_pct);
        logic [15:0] y, x;
        int          calm_left;
        calm_left = 0;
        for (int n = 0; n < count; n++) begin
            if (calm_left == 0 && $urandom_range(39) == 0)
                calm_left = $urandom_range(30, 10);
            make_pair(y, x);
            send_pair(y, x, (calm_left > 0) ? 0 : idle_pct);
            if (calm_left > 0)
                calm_left--;
        end
        wait_for_results();
    endtask

    // Origin, the axes, ratio of one, most negative values and small ratios.
    int dir_y [24] = '{0, 0, 0, 0, 0, 1, -1, 32767, -32768, 32767, -32768, -32768,
                       32767, 1, -1, 1, -1, -32768, -1, 12345, 100, 32767, 1, -32768};
    int dir_x [24] = '{0, 1, -1, 32767, -32768, 0, 0, 32767, -32768, -32768, 32767, 0,
                       0, 1, -1, -1, 1, -1, -32768, -23456, 200, 32766, 32767, 32768};

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < 24; k++)
            send_pair(16'(dir_y[k]), 16'(dir_x[k]), 0);
        wait_for_results();

        run_random(420, 18);
        run_random(420, 64);
        run_random(410, 0);

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
